### sv/rqb_pkg.sv
// ============================================================================
// rqb_pkg
// Types and constants shared by the retry queue with backoff.
// ============================================================================
package rqb_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_RETRY  = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_REMOVE = 2'd3
    } rqb_cmd_t;

    typedef struct packed {
        rqb_cmd_t    cmd;
        logic [31:0] key;
        logic        manual_req;
        logic [4:0]  slot_index;
        logic [7:0]  retry_count;
        logic [9:0]  jitter_ms;
        logic [31:0] now_ms;
    } rqb_in_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  found_slot;
        logic [23:0] backoff_ms;
        logic [31:0] entry_key;
        logic        entry_manual;
        logic [7:0]  entry_retries;
    } rqb_out_t;

    typedef struct packed {
        logic        manual;
        logic [7:0]  retries;
        logic [31:0] next_time;
    } rqb_entry_t;

    typedef struct packed {
        logic       used;
        rqb_entry_t ent;
    } rqb_rd_t;

    typedef struct packed {
        logic used_we;
        logic used_val;
        logic key_we;
        logic man_we;
        logic ret_we;
        logic time_we;
    } rqb_wr_ctl_t;

    localparam logic [15:0] BASE_BACKOFF_RESET = 16'd2000;
    localparam logic [23:0] MAX_BACKOFF_RESET  = 24'd60000;

    localparam logic REG_BASE_IDX = 1'b0;
    localparam logic REG_MAX_IDX  = 1'b1;

endpackage

### sv/retry_queue_with_backoff.sv
// ============================================================================
// retry_queue_with_backoff
// Table of retry entries with add/bump, find-ready, scheduled retry with
// exponential backoff, and remove.
// ============================================================================
// The input channel (s_valid, s_ready, s_data) takes one command per transfer
// and the result channel (m_valid, m_ready, m_data) returns exactly one result
// per command, in order. The APB port sets the base and maximum backoff.
// One command is worked on at a time; s_ready is high only while idle.
// Add and find ready scan the table one entry per cycle through the table's
// registered read port; a match or a ready entry ends the scan early.
// Schedule retry runs the backoff unit, one doubling per cycle: a retry
// count of n allows at most n - 1 doublings, and with a nonzero base the
// cap stops them after 23. Remove and refused commands skip the scan and
// the backoff unit and go from the execute state straight to done.
// The result sits in an output register; a new command is accepted while it
// waits. When the receiver stalls, a second finished result holds in the
// sequencer until the output register frees.
// Reset empties the table at once (used marks are flip-flops) and loads the
// backoff registers with 2000 ms and 60000 ms.
// ============================================================================
module retry_queue_with_backoff #(
    parameter int QUEUE_DEPTH = 32,
    parameter int KEY_BITS    = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rqb_pkg::rqb_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rqb_pkg::rqb_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rqb_pkg::*;

    localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_CNT = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [IDX_W:0]   SCAN_STEP = (IDX_W + 1)'(1);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_EXEC    = 5'b00010,
        ST_SCAN    = 5'b00100,
        ST_BACKOFF = 5'b01000,
        ST_DONE    = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    rqb_in_t     in_reg, in_next;
    rqb_out_t    res_reg, res_next;
    rqb_out_t    out_reg, out_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] base_reg, base_next;
    logic [23:0] max_reg, max_next;

    logic [IDX_W:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             chk_valid_reg, chk_valid_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    rqb_rd_t          rd_data;
    logic [KW-1:0]    rd_key;
    logic [IDX_W-1:0] wr_addr;
    rqb_wr_ctl_t      wr_ctl;
    logic [KW-1:0]    wr_key;
    rqb_entry_t       wr_ent;

    logic        bo_start;
    logic        bo_done;
    logic [23:0] bo_value;

    logic [KW-1:0]    key_m;
    logic             slot_ok;
    logic [IDX_W-1:0] slot_addr;
    logic             issue;
    logic [31:0]      tdiff;
    logic             is_ready;
    logic [31:0]      chk_idx_w;
    logic             cfg_we;

    rqb_table #(
        .DEPTH (QUEUE_DEPTH),
        .KW    (KW),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .rd_key  (rd_key),
        .wr_addr (wr_addr),
        .wr_ctl  (wr_ctl),
        .wr_key  (wr_key),
        .wr_ent  (wr_ent)
    );

    rqb_backoff u_backoff (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bo_start),
        .base    (base_reg),
        .lim     (max_reg),
        .count   (in_reg.retry_count),
        .jitter  (in_reg.jitter_ms),
        .done    (bo_done),
        .value   (bo_value)
    );

    assign key_m     = in_reg.key[KW-1:0];
    assign slot_ok   = (32'(in_reg.slot_index) < QUEUE_DEPTH);
    assign slot_addr = IDX_W'(in_reg.slot_index);
    assign issue     = (scan_idx_reg < DEPTH_CNT);
    assign tdiff     = in_reg.now_ms - rd_data.ent.next_time;
    assign is_ready  = rd_data.used && ((rd_data.ent.next_time == 32'd0) || !tdiff[31]);
    assign chk_idx_w = 32'(chk_idx_reg);

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_IDX) ? {8'd0, max_reg} : {16'd0, base_reg};

    always_comb begin
        base_next = base_reg;
        max_next  = max_reg;
        if (cfg_we) begin
            if (paddr[2] == REG_BASE_IDX) begin
                base_next = pwdata[15:0];
            end else begin
                max_next = pwdata[23:0];
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        in_next         = in_reg;
        res_next        = res_reg;
        scan_idx_next   = scan_idx_reg;
        chk_idx_next    = scan_idx_reg[IDX_W-1:0];
        chk_valid_next  = 1'b0;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        wr_addr         = chk_idx_reg;
        wr_ctl          = '0;
        wr_key          = key_m;
        wr_ent          = '0;
        bo_start        = 1'b0;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next        = '0;
                scan_idx_next   = '0;
                free_found_next = 1'b0;
                unique case (in_reg.cmd)
                    CMD_ADD: begin
                        state_next = (key_m == '0) ? ST_DONE : ST_SCAN;
                    end
                    CMD_FIND: begin
                        state_next = ST_SCAN;
                    end
                    CMD_RETRY: begin
                        if (slot_ok) begin
                            bo_start   = 1'b1;
                            state_next = ST_BACKOFF;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    CMD_REMOVE: begin
                        if (slot_ok) begin
                            wr_addr         = slot_addr;
                            wr_ctl.used_we  = 1'b1;
                            wr_ctl.used_val = 1'b0;
                            res_next.ok     = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (issue) begin
                    scan_idx_next  = scan_idx_reg + SCAN_STEP;
                    chk_valid_next = 1'b1;
                end
                if (chk_valid_reg) begin
                    if (in_reg.cmd == CMD_ADD) begin
                        if (rd_data.used && (rd_key == key_m)) begin
                            wr_addr        = chk_idx_reg;
                            wr_ctl.man_we  = 1'b1;
                            wr_ctl.time_we = 1'b1;
                            wr_ent.manual  = rd_data.ent.manual | in_reg.manual_req;
                            res_next.ok    = 1'b1;
                            chk_valid_next = 1'b0;
                            state_next     = ST_DONE;
                        end else begin
                            if (!rd_data.used && !free_found_reg) begin
                                free_found_next = 1'b1;
                                free_idx_next   = chk_idx_reg;
                            end
                            if (chk_idx_reg == LAST_IDX) begin
                                chk_valid_next = 1'b0;
                                state_next     = ST_DONE;
                                if (free_found_next) begin
                                    wr_addr         = free_idx_next;
                                    wr_ctl          = '1;
                                    wr_ctl.used_val = 1'b1;
                                    wr_ent.manual   = in_reg.manual_req;
                                    res_next.ok     = 1'b1;
                                end
                            end
                        end
                    end else begin
                        if (is_ready) begin
                            res_next.ok            = 1'b1;
                            res_next.found_slot    = chk_idx_w[4:0];
                            res_next.entry_key     = 32'(rd_key);
                            res_next.entry_manual  = rd_data.ent.manual;
                            res_next.entry_retries = rd_data.ent.retries;
                            chk_valid_next         = 1'b0;
                            state_next             = ST_DONE;
                        end else if (chk_idx_reg == LAST_IDX) begin
                            chk_valid_next = 1'b0;
                            state_next     = ST_DONE;
                        end
                    end
                end
            end
            ST_BACKOFF: begin
                if (bo_done) begin
                    wr_addr            = slot_addr;
                    wr_ctl.ret_we      = 1'b1;
                    wr_ctl.time_we     = 1'b1;
                    wr_ent.retries     = in_reg.retry_count;
                    wr_ent.next_time   = in_reg.now_ms + {8'd0, bo_value};
                    res_next.ok        = 1'b1;
                    res_next.backoff_ms = bo_value;
                    state_next         = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            chk_valid_reg <= 1'b0;
            base_reg      <= BASE_BACKOFF_RESET;
            max_reg       <= MAX_BACKOFF_RESET;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            chk_valid_reg <= chk_valid_next;
            base_reg      <= base_next;
            max_reg       <= max_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg         <= in_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

### sv/rqb_table.sv
// ============================================================================
// rqb_table
// Entry storage: used marks in flip-flops, entry fields in memories with
// per-field write enables and one registered read port.
// ============================================================================
module rqb_table #(
    parameter int DEPTH = 32,
    parameter int KW    = 32,
    parameter int IDX_W = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IDX_W-1:0]     rd_addr,
    output rqb_pkg::rqb_rd_t     rd_data,
    output logic [KW-1:0]        rd_key,
    input  logic [IDX_W-1:0]     wr_addr,
    input  rqb_pkg::rqb_wr_ctl_t wr_ctl,
    input  logic [KW-1:0]        wr_key,
    input  rqb_pkg::rqb_entry_t  wr_ent
);
    import rqb_pkg::*;

    logic [DEPTH-1:0] used_reg;
    logic [KW-1:0]    key_mem  [DEPTH];
    logic             man_mem  [DEPTH];
    logic [7:0]       ret_mem  [DEPTH];
    logic [31:0]      time_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (wr_ctl.used_we) begin
            used_reg[wr_addr] <= wr_ctl.used_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ctl.key_we) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_ctl.man_we) begin
            man_mem[wr_addr] <= wr_ent.manual;
        end
        if (wr_ctl.ret_we) begin
            ret_mem[wr_addr] <= wr_ent.retries;
        end
        if (wr_ctl.time_we) begin
            time_mem[wr_addr] <= wr_ent.next_time;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data.used          <= used_reg[rd_addr];
        rd_data.ent.manual    <= man_mem[rd_addr];
        rd_data.ent.retries   <= ret_mem[rd_addr];
        rd_data.ent.next_time <= time_mem[rd_addr];
        rd_key                <= key_mem[rd_addr];
    end

endmodule

### sv/rqb_backoff.sv
// ============================================================================
// rqb_backoff
// Iterative backoff unit: doubles the base once per cycle until the retry
// count or the cap stops it, then adds jitter and clamps in a final cycle.
// ============================================================================
module rqb_backoff (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] base,
    input  logic [23:0] lim,
    input  logic [7:0]  count,
    input  logic [9:0]  jitter,
    output logic        done,
    output logic [23:0] value
);
    import rqb_pkg::*;

    logic        run_reg, run_next;
    logic        fin_reg, fin_next;
    logic        done_reg, done_next;
    logic [23:0] b_reg, b_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [23:0] value_reg, value_next;
    logic [23:0] b_cap;
    logic [24:0] sum;

    always_comb begin
        run_next   = run_reg;
        fin_next   = fin_reg;
        done_next  = 1'b0;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        value_next = value_reg;
        b_cap      = (b_reg > lim) ? lim : b_reg;
        sum        = {1'b0, b_cap} + {15'd0, jitter};
        if (start) begin
            b_next   = {8'd0, base};
            cnt_next = count;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (cnt_reg <= 8'd1) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end else if (b_reg >= {1'b0, lim[23:1]}) begin
                b_next   = lim;
                run_next = 1'b0;
                fin_next = 1'b1;
            end else begin
                b_next   = {b_reg[22:0], 1'b0};
                cnt_next = cnt_reg - 8'd1;
            end
        end else if (fin_reg) begin
            value_next = (sum > {1'b0, lim}) ? lim : sum[23:0];
            done_next  = 1'b1;
            fin_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg     <= b_next;
        cnt_reg   <= cnt_next;
        value_reg <= value_next;
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule
